[rtl/msp_pkg.sv]
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and defaults of the multi-stack shared pool unit.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

   localparam int DEF_NUM_STACKS = 10;
   localparam int DEF_POOL_DEPTH = 64;
   localparam int DEF_KEY_WIDTH  = 32;

   localparam int IDX_W    = 4;
   localparam int STATUS_W = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_COMMIT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic fetch;
      logic commit;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic pop_fetch;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/msp_ram.sv]
// ----------------------------------------------------------------------------
// msp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/msp_ctrl.sv]
// ----------------------------------------------------------------------------
// msp_ctrl
// Operation sequencer: accept, optional node fetch for a pop, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire msp_pkg::dp_status_type status,
   output      msp_pkg::ctrl_cmd_type  cmd
);

   msp_pkg::state_type state_ff;
   msp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msp_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = status.pop_fetch ? msp_pkg::S_FETCH : msp_pkg::S_COMMIT;
            end
         end
         msp_pkg::S_FETCH: begin
            state_in = msp_pkg::S_COMMIT;
         end
         msp_pkg::S_COMMIT: begin
            if (!status.out_busy) begin
               state_in = msp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = msp_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         msp_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         msp_pkg::S_FETCH: begin
            cmd.fetch = 1'b1;
         end
         msp_pkg::S_COMMIT: begin
            cmd.commit = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // a new transaction is only taken with the sequencer at rest
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == msp_pkg::S_IDLE) && !req_stall)
      else $error("load issued outside idle");

   a_fetch_then_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> (state_ff == msp_pkg::S_COMMIT))
      else $error("fetch not followed by commit");

   a_commit_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !status.out_busy)
      else $error("commit while result register is held");

endmodule

`default_nettype wire

[rtl/msp_datapath.sv]
// ----------------------------------------------------------------------------
// msp_datapath
// Stack tops, node pool, free list and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_datapath #(
   parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
   parameter int POOL_DEPTH = msp_pkg::DEF_POOL_DEPTH,
   parameter int KEY_WIDTH  = msp_pkg::DEF_KEY_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire msp_pkg::ctrl_cmd_type         cmd,
   output      msp_pkg::dp_status_type        status,
   input  wire logic                          req_op,
   input  wire logic [msp_pkg::IDX_W-1:0]     req_stack_index,
   input  wire logic signed [KEY_WIDTH-1:0]   req_key,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [KEY_WIDTH-1:0]   rsp_popped_key,
   output      logic [msp_pkg::STATUS_W-1:0]  rsp_status,
   output      logic                          rsp_stack_empty
);

   localparam int SIDX_W = $clog2(NUM_STACKS);
   localparam int PTR_W  = $clog2(POOL_DEPTH);
   localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

   // latched transaction
   logic                 op_ff;
   logic [SIDX_W-1:0]    sidx_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic                 ok_ff;
   logic                 tv_ff;
   logic [PTR_W-1:0]     node_ff;

   // pool control state
   logic [NUM_STACKS-1:0] top_valid_ff, top_valid_in;
   logic [PTR_W-1:0]      free_head_ff, free_head_in;
   logic [CNT_W-1:0]      free_count_ff, free_count_in;
   logic [CNT_W-1:0]      alloc_ptr_ff, alloc_ptr_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0]        popped_ff, popped_in;
   logic [msp_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                        empty_ff, empty_in;

   // memory ports
   logic                 top_we, next_we, key_we;
   logic [PTR_W-1:0]     top_wdata;
   logic [PTR_W:0]       next_wdata;
   logic [PTR_W-1:0]     next_waddr;
   logic [PTR_W-1:0]     next_raddr;
   logic [PTR_W-1:0]     top_rd;
   logic [PTR_W:0]       next_rd;
   logic [KEY_WIDTH-1:0] key_rd;

   logic [SIDX_W-1:0]    req_sidx;
   logic                 req_ok;
   logic                 req_tv;
   logic                 is_tail;
   logic [PTR_W-1:0]     tail_next;

   assign req_sidx = SIDX_W'(req_stack_index);
   assign req_ok   = (32'(req_stack_index) < 32'(NUM_STACKS));
   assign req_tv   = req_ok && top_valid_ff[req_sidx];

   assign status.pop_fetch = (req_op == msp_pkg::OP_POP) && req_tv;
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

   // nodes at or above the allocation mark have never been written, so their link is not used
   assign is_tail   = (CNT_W'(free_head_ff) == alloc_ptr_ff);
   assign tail_next = (alloc_ptr_ff == CNT_W'(POOL_DEPTH - 1)) ? '0
                                                             : PTR_W'(alloc_ptr_ff + CNT_W'(1));

   assign next_raddr = cmd.load ? free_head_ff : top_rd;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         sidx_ff <= req_sidx;
         key_ff  <= req_key;
         ok_ff   <= req_ok;
         tv_ff   <= req_tv;
      end
      if (cmd.fetch) begin
         node_ff <= top_rd;
      end
      popped_ff <= popped_in;
      status_ff <= status_in;
      empty_ff  <= empty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_valid_ff  <= '0;
         free_head_ff  <= '0;
         free_count_ff <= CNT_W'(POOL_DEPTH);
         alloc_ptr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         top_valid_ff  <= top_valid_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         alloc_ptr_ff  <= alloc_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_comb begin
      top_valid_in  = top_valid_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      alloc_ptr_in  = alloc_ptr_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      empty_in      = empty_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      top_we        = 1'b0;
      top_wdata     = top_rd;
      key_we        = 1'b0;
      next_we       = 1'b0;
      next_waddr    = free_head_ff;
      next_wdata    = next_rd;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         popped_in    = '0;
         status_in    = msp_pkg::ST_OK;
         if (op_ff == msp_pkg::OP_PUSH) begin
            if (!ok_ff || (free_count_ff == '0)) begin
               status_in = msp_pkg::ST_FULL;
               empty_in  = !tv_ff;
            end else begin
               empty_in              = 1'b0;
               top_we                = 1'b1;
               top_wdata             = free_head_ff;
               key_we                = 1'b1;
               next_we               = 1'b1;
               next_waddr            = free_head_ff;
               next_wdata            = {tv_ff, top_rd};
               top_valid_in[sidx_ff] = 1'b1;
               free_count_in         = free_count_ff - CNT_W'(1);
               if (is_tail) begin
                  free_head_in = tail_next;
                  alloc_ptr_in = alloc_ptr_ff + CNT_W'(1);
               end else begin
                  free_head_in = next_rd[PTR_W-1:0];
               end
            end
         end else begin
            if (!tv_ff) begin
               status_in = msp_pkg::ST_EMPTY;
               empty_in  = 1'b1;
            end else begin
               popped_in             = key_rd;
               empty_in              = !next_rd[PTR_W];
               top_we                = 1'b1;
               top_wdata             = next_rd[PTR_W-1:0];
               top_valid_in[sidx_ff] = next_rd[PTR_W];
               next_we               = 1'b1;
               next_waddr            = node_ff;
               next_wdata            = {1'b0, free_head_ff};
               free_head_in          = node_ff;
               free_count_in         = free_count_ff + CNT_W'(1);
            end
         end
      end
   end

   msp_ram #(.WIDTH(PTR_W), .DEPTH(NUM_STACKS)) u_top_ram (
      .clock   (clock),
      .wr_en   (top_we),
      .wr_addr (sidx_ff),
      .wr_data (top_wdata),
      .rd_en   (cmd.load),
      .rd_addr (req_sidx),
      .rd_data (top_rd)
   );

   msp_ram #(.WIDTH(PTR_W + 1), .DEPTH(POOL_DEPTH)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (cmd.load || cmd.fetch),
      .rd_addr (next_raddr),
      .rd_data (next_rd)
   );

   msp_ram #(.WIDTH(KEY_WIDTH), .DEPTH(POOL_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (free_head_ff),
      .wr_data (key_ff),
      .rd_en   (cmd.fetch),
      .rd_addr (top_rd),
      .rd_data (key_rd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_popped_key  = $signed(popped_ff);
   assign rsp_status      = status_ff;
   assign rsp_stack_empty = empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(POOL_DEPTH))
      else $error("free count above pool depth");

   a_head_below_mark: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(free_head_ff) <= alloc_ptr_ff)
      else $error("free head beyond allocation mark");

   a_push_takes_node: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (op_ff == msp_pkg::OP_PUSH) && ok_ff && (free_count_ff != '0)
      |=> (free_count_ff == $past(free_count_ff) - CNT_W'(1)))
      else $error("push did not take a node");

endmodule

`default_nettype wire

[rtl/multi_stack_shared_pool_unit.sv]
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_unit
// Several LIFO stacks linked through one shared pool of nodes.
// ----------------------------------------------------------------------------
// Each transaction names a stack and pushes a key onto it or pops its top key;
// nodes come from and return to one shared free list. One result follows every
// transaction and reports the stack's empty flag after the operation. A push
// and any failed operation go from accept straight to commit; a successful pop
// passes through a fetch state: the stack top is read from its registered-read
// RAM first, and a pop then needs a second registered read of the node key and
// link RAMs before the commit. A new transaction is taken once the commit is
// done, even while the previous result waits on rsp_stall; the commit itself
// waits while the result register is held. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_shared_pool_unit #(
   parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
   parameter int POOL_DEPTH = msp_pkg::DEF_POOL_DEPTH,
   parameter int KEY_WIDTH  = msp_pkg::DEF_KEY_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_op,
   input  wire logic [msp_pkg::IDX_W-1:0]     req_stack_index,
   input  wire logic signed [KEY_WIDTH-1:0]   req_key,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [KEY_WIDTH-1:0]   rsp_popped_key,
   output      logic [msp_pkg::STATUS_W-1:0]  rsp_status,
   output      logic                          rsp_stack_empty
);

   msp_pkg::ctrl_cmd_type  cmd;
   msp_pkg::dp_status_type status;

   msp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msp_datapath #(
      .NUM_STACKS (NUM_STACKS),
      .POOL_DEPTH (POOL_DEPTH),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_stack_index (req_stack_index),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_popped_key  (rsp_popped_key),
      .rsp_status      (rsp_status),
      .rsp_stack_empty (rsp_stack_empty)
   );

endmodule

`default_nettype wire
